[sv/ffc_pkg.sv]
// Shared constants, types and helper functions for the farthest free cell core.
package ffc_pkg;

   localparam int GRID_MAX = 64;
   localparam int FIELD_W  = 7;
   localparam int IDX_W    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
   localparam int SIZE_W   = $clog2(GRID_MAX + 1);
   // One spare bit above the largest real distance leaves room for the far-away marker
   localparam int DIST_W   = $clog2(2 * GRID_MAX) + 1;
   localparam int CMP_W    = (SIZE_W > FIELD_W) ? SIZE_W : FIELD_W;

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [SIZE_W-1:0]    size_type;
   typedef logic [DIST_W-1:0]    dist_type;
   typedef logic [2*IDX_W-1:0]   addr_type;
   typedef logic [FIELD_W-1:0]   field_type;
   typedef logic [CMP_W-1:0]     cmp_type;
   typedef logic [1:0]           code_type;
   typedef logic [GRID_MAX-1:0]  row_type;

   localparam dist_type  DIST_INF        = '1;
   localparam field_type GRID_SIZE_RESET = 7'd64;
   localparam int        DIST_OUT_MAX    = 127;

   localparam code_type ACT_MARK  = 2'd0;
   localparam code_type ACT_FIND  = 2'd1;
   localparam code_type ACT_CLEAR = 2'd2;

   localparam code_type STAT_FOUND = 2'd0;
   localparam code_type STAT_EMPTY = 2'd1;
   localparam code_type STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FWD_RD,
      ST_FWD_WR,
      ST_BWD_RD,
      ST_BWD_WR,
      ST_DONE
   } state_type;

   // Clamp the programmed side length into 1 .. GRID_MAX
   function automatic size_type size_in_use(field_type gs);
      size_type n;
      if (gs == '0) begin
         n = size_type'(1);
      end else if (cmp_type'(gs) > cmp_type'(GRID_MAX)) begin
         n = size_type'(GRID_MAX);
      end else begin
         n = size_type'(gs);
      end
      return n;
   endfunction

   // Add one, keeping the far-away marker where it is
   function automatic dist_type sat_inc(dist_type d);
      return (d == DIST_INF) ? DIST_INF : d + dist_type'(1);
   endfunction

   function automatic dist_type dist_min(dist_type a, dist_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic field_type dist_out(dist_type d);
      field_type v;
      if (int'(d) > DIST_OUT_MAX) begin
         v = field_type'(DIST_OUT_MAX);
      end else begin
         v = field_type'(d);
      end
      return v;
   endfunction

endpackage

[sv/farthest_free_cell_l1_core.sv]
// Occupancy grid with an iterative L1 distance transform and farthest free cell search.
//
// Usage: present an item on req_action/req_row/req_col with start high; it is taken at
// a rising edge where start is high and busy is low. Mark (action 0) sets one cell of
// the grid in use and clear (action 2) empties the grid; neither gives a result, so
// marks and clears may follow one another every cycle. Action 3 is ignored.
// A find (action 1) raises busy and walks the grid in use (n by n, n from grid_size)
// cell by cell through one shared min/increment unit and a distance memory: a forward
// pass, then, unless the grid is empty or full, a backward pass that also tracks the
// best cell. Each cell takes a read state and a write state because the distance
// memory read is registered. The result then shows on rsp_* for one cycle with
// rsp_valid high, in the done state after the last pass. The result must be taken in
// that cycle; there is no back-pressure.
// grid_size is written through csr_valid/csr_wdata (csr_ready is always high); the user
// must do so while idle; the block does not enforce it. Reset returns the sequencer to
// idle, sets grid_size to 64 and empties the grid at once through per-row valid bits.
module farthest_free_cell_l1_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ffc_pkg::code_type     req_action,
   input  ffc_pkg::field_type    req_row,
   input  ffc_pkg::field_type    req_col,
   output logic                  rsp_valid,
   output ffc_pkg::code_type     rsp_status,
   output ffc_pkg::field_type    rsp_best_row,
   output ffc_pkg::field_type    rsp_best_col,
   output ffc_pkg::field_type    rsp_best_distance,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  ffc_pkg::field_type    csr_wdata
);

   ffc_pkg::state_type  state_ff, state_in;
   ffc_pkg::field_type  grid_size_ff;
   ffc_pkg::row_type    occ_vld_ff;

   ffc_pkg::row_type    occ_mem [ffc_pkg::GRID_MAX];
   ffc_pkg::dist_type   dist_mem [2 ** (2 * ffc_pkg::IDX_W)];

   ffc_pkg::row_type    occ_rd_ff;
   logic                occ_vld_rd_ff;
   ffc_pkg::dist_type   dist_rd_a_ff, dist_rd_b_ff;

   ffc_pkg::size_type   n_cur, n_ff;
   ffc_pkg::idx_type    r_ff, c_ff, last_idx, mark_r, mark_c;
   ffc_pkg::dist_type   side_ff, best_d_ff;
   ffc_pkg::idx_type    best_r_ff, best_c_ff;
   logic                any_occ_ff, any_free_ff, found_ff;

   ffc_pkg::code_type   rsp_status_ff;
   ffc_pkg::field_type  rsp_row_ff, rsp_col_ff, rsp_dist_ff;

   logic                accept, mark_ok, mark_we, clear_go, find_go;
   logic                fwd_pass, fwd_wr, dist_we;
   logic                occ_bit, any_occ_in, any_free_in;
   logic                fwd_last, bwd_last, take;
   logic                vert_en, side_en;
   ffc_pkg::dist_type   base, vert, d_new;
   ffc_pkg::addr_type   dist_ra, dist_rb, dist_wa;

   // ---------------------------------------------------------------- front end
   assign csr_ready = 1'b1;
   assign n_cur     = ffc_pkg::size_in_use(grid_size_ff);
   assign accept    = start && !busy;

   assign mark_ok = (req_row != '0) && (req_col != '0)
                 && (ffc_pkg::cmp_type'(req_row) <= ffc_pkg::cmp_type'(n_cur))
                 && (ffc_pkg::cmp_type'(req_col) <= ffc_pkg::cmp_type'(n_cur));
   assign mark_we  = accept && (req_action == ffc_pkg::ACT_MARK) && mark_ok;
   assign clear_go = accept && (req_action == ffc_pkg::ACT_CLEAR);
   assign find_go  = accept && (req_action == ffc_pkg::ACT_FIND);
   assign mark_r   = ffc_pkg::idx_type'(req_row - ffc_pkg::field_type'(1));
   assign mark_c   = ffc_pkg::idx_type'(req_col - ffc_pkg::field_type'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= ffc_pkg::GRID_SIZE_RESET;
         occ_vld_ff   <= '0;
         state_ff     <= ffc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            grid_size_ff <= csr_wdata;
         end
         if (clear_go) begin
            occ_vld_ff <= '0;
         end else if (mark_we) begin
            occ_vld_ff[mark_r] <= 1'b1;
         end
      end
   end

   // Occupancy rows: a row whose valid bit is low reads as all free
   always_ff @(posedge clock) begin
      if (mark_we) begin
         if (occ_vld_ff[mark_r]) begin
            occ_mem[mark_r][mark_c] <= 1'b1;
         end else begin
            occ_mem[mark_r] <= ffc_pkg::row_type'(1) << mark_c;
         end
      end
      occ_rd_ff     <= occ_mem[r_ff];
      occ_vld_rd_ff <= occ_vld_ff[r_ff];
   end

   // ---------------------------------------------------------------- sequencer
   assign last_idx = ffc_pkg::idx_type'(n_ff - ffc_pkg::size_type'(1));
   assign fwd_last = (r_ff == last_idx) && (c_ff == last_idx);
   assign bwd_last = (r_ff == '0) && (c_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffc_pkg::ST_IDLE: begin
            if (find_go) state_in = ffc_pkg::ST_FWD_RD;
         end
         ffc_pkg::ST_FWD_RD: begin
            state_in = ffc_pkg::ST_FWD_WR;
         end
         ffc_pkg::ST_FWD_WR: begin
            if (!fwd_last) begin
               state_in = ffc_pkg::ST_FWD_RD;
            end else if (any_occ_in && any_free_in) begin
               state_in = ffc_pkg::ST_BWD_RD;
            end else begin
               state_in = ffc_pkg::ST_DONE;
            end
         end
         ffc_pkg::ST_BWD_RD: begin
            state_in = ffc_pkg::ST_BWD_WR;
         end
         ffc_pkg::ST_BWD_WR: begin
            state_in = bwd_last ? ffc_pkg::ST_DONE : ffc_pkg::ST_BWD_RD;
         end
         ffc_pkg::ST_DONE: begin
            state_in = ffc_pkg::ST_IDLE;
         end
         default: begin
            state_in = ffc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      fwd_pass  = 1'b0;
      fwd_wr    = 1'b0;
      dist_we   = 1'b0;
      unique case (state_ff)
         ffc_pkg::ST_IDLE:   busy = 1'b0;
         ffc_pkg::ST_FWD_RD: fwd_pass = 1'b1;
         ffc_pkg::ST_FWD_WR: begin
            fwd_pass = 1'b1;
            fwd_wr   = 1'b1;
            dist_we  = 1'b1;
         end
         ffc_pkg::ST_BWD_RD: ;
         ffc_pkg::ST_BWD_WR: dist_we = 1'b1;
         ffc_pkg::ST_DONE:   rsp_valid = 1'b1;
         default:            busy = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------- distance memory
   // Forward pass reads the cell above; backward pass reads this cell and the one below
   assign dist_ra = fwd_pass ? {r_ff - ffc_pkg::idx_type'(1), c_ff} : {r_ff, c_ff};
   assign dist_rb = {r_ff + ffc_pkg::idx_type'(1), c_ff};
   assign dist_wa = {r_ff, c_ff};

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= d_new;
      end
      dist_rd_a_ff <= dist_mem[dist_ra];
      dist_rd_b_ff <= dist_mem[dist_rb];
   end

   // ---------------------------------------------------------------- shared min unit
   assign occ_bit     = occ_vld_rd_ff && occ_rd_ff[c_ff];
   assign any_occ_in  = any_occ_ff || occ_bit;
   assign any_free_in = any_free_ff || !occ_bit;

   always_comb begin
      base    = fwd_wr ? (occ_bit ? '0 : ffc_pkg::DIST_INF) : dist_rd_a_ff;
      vert    = fwd_wr ? dist_rd_a_ff : dist_rd_b_ff;
      vert_en = fwd_wr ? (r_ff != '0) : (r_ff != last_idx);
      side_en = fwd_wr ? (c_ff != '0) : (c_ff != last_idx);
      d_new   = base;
      if (vert_en) d_new = ffc_pkg::dist_min(d_new, ffc_pkg::sat_inc(vert));
      if (side_en) d_new = ffc_pkg::dist_min(d_new, ffc_pkg::sat_inc(side_ff));
   end

   // Walking backwards, >= keeps the first maximum in row-major order
   assign take = !occ_bit && (!found_ff || (d_new >= best_d_ff));

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ffc_pkg::ST_IDLE: begin
            if (find_go) begin
               n_ff        <= n_cur;
               r_ff        <= '0;
               c_ff        <= '0;
               any_occ_ff  <= 1'b0;
               any_free_ff <= 1'b0;
               found_ff    <= 1'b0;
            end
         end
         ffc_pkg::ST_FWD_WR: begin
            side_ff     <= d_new;
            any_occ_ff  <= any_occ_in;
            any_free_ff <= any_free_in;
            if (fwd_last) begin
               r_ff <= last_idx;
               c_ff <= last_idx;
               if (!any_occ_in) begin
                  rsp_status_ff <= ffc_pkg::STAT_EMPTY;
                  rsp_row_ff    <= ffc_pkg::field_type'(1);
                  rsp_col_ff    <= ffc_pkg::field_type'(1);
                  rsp_dist_ff   <= '0;
               end else begin
                  rsp_status_ff <= ffc_pkg::STAT_FULL;
                  rsp_row_ff    <= '0;
                  rsp_col_ff    <= '0;
                  rsp_dist_ff   <= '0;
               end
            end else if (c_ff == last_idx) begin
               c_ff <= '0;
               r_ff <= r_ff + ffc_pkg::idx_type'(1);
            end else begin
               c_ff <= c_ff + ffc_pkg::idx_type'(1);
            end
         end
         ffc_pkg::ST_BWD_WR: begin
            side_ff <= d_new;
            if (take) begin
               found_ff  <= 1'b1;
               best_d_ff <= d_new;
               best_r_ff <= r_ff;
               best_c_ff <= c_ff;
            end
            if (bwd_last) begin
               rsp_status_ff <= ffc_pkg::STAT_FOUND;
               rsp_row_ff    <= ffc_pkg::field_type'(take ? r_ff : best_r_ff)
                              + ffc_pkg::field_type'(1);
               rsp_col_ff    <= ffc_pkg::field_type'(take ? c_ff : best_c_ff)
                              + ffc_pkg::field_type'(1);
               rsp_dist_ff   <= ffc_pkg::dist_out(take ? d_new : best_d_ff);
            end
            if (c_ff == '0) begin
               c_ff <= last_idx;
               r_ff <= r_ff - ffc_pkg::idx_type'(1);
            end else begin
               c_ff <= c_ff - ffc_pkg::idx_type'(1);
            end
         end
         default: ;
      endcase
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_best_row      = rsp_row_ff;
   assign rsp_best_col      = rsp_col_ff;
   assign rsp_best_distance = rsp_dist_ff;

   // ---------------------------------------------------------------- assertions
   a_find_goes_busy: assert property (@(posedge clock) disable iff (reset)
      find_go |=> busy)
      else $error("find transaction did not start the sequencer");

   a_bwd_needs_mixed_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffc_pkg::ST_BWD_WR) |-> (any_occ_ff && any_free_ff))
      else $error("backward pass entered on an empty or full grid");

   a_found_slot_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ffc_pkg::STAT_FOUND))
         |-> ((rsp_best_row != '0) && (rsp_best_col != '0)))
      else $error("found result carries a zero slot");

   a_full_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ffc_pkg::STAT_FULL))
         |-> ((rsp_best_row == '0) && (rsp_best_col == '0) && (rsp_best_distance == '0)))
      else $error("full-grid result is not all zero");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

[test/farthest_cell_checker.sv]
// Grid mirror and placement scoreboard for the farthest free cell core.
`timescale 1ns / 100ps
module farthest_cell_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  ffc_pkg::code_type   req_action,
   input  ffc_pkg::field_type  req_row,
   input  ffc_pkg::field_type  req_col,
   input  logic                rsp_valid,
   input  ffc_pkg::code_type   rsp_status,
   input  ffc_pkg::field_type  rsp_best_row,
   input  ffc_pkg::field_type  rsp_best_col,
   input  ffc_pkg::field_type  rsp_best_distance,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  ffc_pkg::field_type  csr_wdata,
   output int unsigned         mismatch_count,
   output int unsigned         pending_count,
   output int unsigned         checked_count,
   output int unsigned         found_count,
   output int unsigned         empty_count,
   output int unsigned         full_count
);

   typedef struct packed {
      ffc_pkg::code_type  status;
      ffc_pkg::field_type row;
      ffc_pkg::field_type col;
      ffc_pkg::field_type distance;
   } placement_type;

   localparam int UNREACHED = 1 << 20;

   bit [ffc_pkg::GRID_MAX-1:0] occupied [ffc_pkg::GRID_MAX];
   ffc_pkg::field_type         side_reg;
   placement_type              pending_placements [$];

   function automatic int side_of(ffc_pkg::field_type g);
      if (g == '0) return 1;
      if (int'(g) > ffc_pkg::GRID_MAX) return ffc_pkg::GRID_MAX;
      return int'(g);
   endfunction

   // L1 distance transform over the n by n corner, then the first cell with the largest reach
   function automatic placement_type predict_placement(int n);
      int            reach [ffc_pkg::GRID_MAX][ffc_pkg::GRID_MAX];
      int            taken;
      int            best;
      int            best_r;
      int            best_c;
      placement_type p;
      taken = 0;
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            if (occupied[r][c]) taken++;
      if (taken == 0) begin
         p = '{ffc_pkg::STAT_EMPTY, ffc_pkg::field_type'(1), ffc_pkg::field_type'(1),
               ffc_pkg::field_type'(0)};
      end else if (taken == n * n) begin
         p = '{ffc_pkg::STAT_FULL, ffc_pkg::field_type'(0), ffc_pkg::field_type'(0),
               ffc_pkg::field_type'(0)};
      end else begin
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               reach[r][c] = occupied[r][c] ? 0 : UNREACHED;
               if (r > 0 && reach[r-1][c] + 1 < reach[r][c]) reach[r][c] = reach[r-1][c] + 1;
               if (c > 0 && reach[r][c-1] + 1 < reach[r][c]) reach[r][c] = reach[r][c-1] + 1;
            end
         end
         for (int r = n - 1; r >= 0; r--) begin
            for (int c = n - 1; c >= 0; c--) begin
               if (r < n - 1 && reach[r+1][c] + 1 < reach[r][c]) reach[r][c] = reach[r+1][c] + 1;
               if (c < n - 1 && reach[r][c+1] + 1 < reach[r][c]) reach[r][c] = reach[r][c+1] + 1;
            end
         end
         best   = -1;
         best_r = 0;
         best_c = 0;
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               // strict compare keeps the first cell in row-major order on a tie
               if (!occupied[r][c] && reach[r][c] > best) begin
                  best   = reach[r][c];
                  best_r = r;
                  best_c = c;
               end
            end
         end
         if (best > ffc_pkg::DIST_OUT_MAX) best = ffc_pkg::DIST_OUT_MAX;
         p = '{ffc_pkg::STAT_FOUND, ffc_pkg::field_type'(best_r + 1),
               ffc_pkg::field_type'(best_c + 1), ffc_pkg::field_type'(best)};
      end
      return p;
   endfunction

   always @(posedge clock) begin
      placement_type want;
      int            n;
      if (reset) begin
         foreach (occupied[r]) occupied[r] = '0;
         side_reg = ffc_pkg::GRID_SIZE_RESET;
         pending_placements.delete();
      end else begin
         n = side_of(side_reg);
         if (rsp_valid === 1'b1) begin
            if (pending_placements.size() == 0) begin
               $error("placement transaction arrived with none outstanding");
               mismatch_count++;
            end else begin
               want = pending_placements.pop_front();
               checked_count++;
               case (want.status)
                  ffc_pkg::STAT_FOUND: found_count++;
                  ffc_pkg::STAT_EMPTY: empty_count++;
                  default:             full_count++;
               endcase
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_best_row !== want.row) begin
                  $error("best_row expected %0d got %0d", want.row, rsp_best_row);
                  mismatch_count++;
               end
               if (rsp_best_col !== want.col) begin
                  $error("best_col expected %0d got %0d", want.col, rsp_best_col);
                  mismatch_count++;
               end
               if (rsp_best_distance !== want.distance) begin
                  $error("best_distance expected %0d got %0d", want.distance, rsp_best_distance);
                  mismatch_count++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            case (req_action)
               ffc_pkg::ACT_MARK: begin
                  // drop marks outside the grid in use
                  if (req_row >= 1 && int'(req_row) <= n && req_col >= 1 && int'(req_col) <= n)
                     occupied[req_row - 1][req_col - 1] = 1'b1;
               end
               ffc_pkg::ACT_FIND: pending_placements.push_back(predict_placement(n));
               ffc_pkg::ACT_CLEAR: begin
                  foreach (occupied[r]) occupied[r] = '0;
               end
               default: ;
            endcase
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) side_reg = csr_wdata;
      end
      pending_count <= pending_placements.size();
   end

endmodule

[test/tb_top.sv]
// Stimulus, clocking and verdict for the farthest free cell core.
`timescale 1ns / 100ps
module tb_top;

   localparam ffc_pkg::code_type ACT_SPARE     = 2'd3;
   localparam int                ITEM_TARGET   = 1750;
   localparam int                BIG_PHASE_MAX = 3;
   localparam int                SETTLE_CYCLES = 4;
   localparam int                DRAIN_LIMIT   = 40000;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               start      = 1'b0;
   logic               busy;
   ffc_pkg::code_type  req_action = '0;
   ffc_pkg::field_type req_row    = '0;
   ffc_pkg::field_type req_col    = '0;
   logic               rsp_valid;
   ffc_pkg::code_type  rsp_status;
   ffc_pkg::field_type rsp_best_row;
   ffc_pkg::field_type rsp_best_col;
   ffc_pkg::field_type rsp_best_distance;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   ffc_pkg::field_type csr_wdata  = '0;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned checked;
   int unsigned n_found;
   int unsigned n_empty;
   int unsigned n_full;

   int applied_items  = 0;
   int find_items     = 0;
   int settings_used  = 0;
   int burst_left     = 0;
   int side           = ffc_pkg::GRID_MAX;
   int big_phases     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   farthest_free_cell_l1_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_row           (req_row),
      .req_col           (req_col),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_best_row      (rsp_best_row),
      .rsp_best_col      (rsp_best_col),
      .rsp_best_distance (rsp_best_distance),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   farthest_cell_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_row           (req_row),
      .req_col           (req_col),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_best_row      (rsp_best_row),
      .rsp_best_col      (rsp_best_col),
      .rsp_best_distance (rsp_best_distance),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatches),
      .pending_count     (pending),
      .checked_count     (checked),
      .found_count       (n_found),
      .empty_count       (n_empty),
      .full_count        (n_full)
   );

   // Present one item and hold it until the core takes the transaction
   task automatic send_item(ffc_pkg::code_type act, ffc_pkg::field_type r,
                            ffc_pkg::field_type c);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start      <= 1'b1;
      req_action <= act;
      req_row    <= r;
      req_col    <= c;
      do @(posedge clock); while (busy !== 1'b0);
      if (act == ffc_pkg::ACT_FIND) find_items++;
      applied_items++;
   endtask

   task automatic mark_in_grid();
      send_item(ffc_pkg::ACT_MARK, ffc_pkg::field_type'($urandom_range(1, side)),
                ffc_pkg::field_type'($urandom_range(1, side)));
   endtask

   task automatic find_now();
      send_item(ffc_pkg::ACT_FIND, ffc_pkg::field_type'($urandom_range(0, 127)),
                ffc_pkg::field_type'($urandom_range(0, 127)));
   endtask

   task automatic clear_now();
      send_item(ffc_pkg::ACT_CLEAR, ffc_pkg::field_type'($urandom_range(0, 127)),
                ffc_pkg::field_type'($urandom_range(0, 127)));
   endtask

   // Write grid_size once the core has drained every outstanding placement
   task automatic set_grid_size(ffc_pkg::field_type v);
      start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (busy !== 1'b0 || pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      side = (v == '0) ? 1 : (int'(v) > ffc_pkg::GRID_MAX) ? ffc_pkg::GRID_MAX : int'(v);
      settings_used++;
   endtask

   initial begin
      int                 pick;
      int                 ops;
      int                 mode;
      int                 hole_a;
      int                 hole_b;
      int                 waited;
      ffc_pkg::field_type size_val;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset size, corners, ignored marks, spare action
      find_now();
      send_item(ffc_pkg::ACT_MARK, 7'd1, 7'd1);
      send_item(ffc_pkg::ACT_MARK, 7'd64, 7'd64);
      send_item(ffc_pkg::ACT_MARK, 7'd0, 7'd5);
      send_item(ffc_pkg::ACT_MARK, 7'd65, 7'd3);
      send_item(ffc_pkg::ACT_MARK, 7'd127, 7'd127);
      send_item(ACT_SPARE, 7'd127, 7'd127);
      find_now();
      send_item(ffc_pkg::ACT_CLEAR, 7'd0, 7'd0);
      find_now();
      // single cell: empty, then full; zero size behaves as one
      set_grid_size(7'd1);
      find_now();
      send_item(ffc_pkg::ACT_MARK, 7'd1, 7'd1);
      send_item(ffc_pkg::ACT_MARK, 7'd2, 7'd2);
      find_now();
      set_grid_size(7'd0);
      find_now();
      // occupied cell outside the size in use stays but is not seen
      set_grid_size(7'd3);
      send_item(ffc_pkg::ACT_CLEAR, 7'd0, 7'd0);
      send_item(ffc_pkg::ACT_MARK, 7'd3, 7'd3);
      set_grid_size(7'd2);
      find_now();
      set_grid_size(7'd127);
      find_now();
      // tie between three corners: first in row-major order wins
      set_grid_size(7'd3);
      send_item(ffc_pkg::ACT_MARK, 7'd2, 7'd2);
      find_now();

      while (applied_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 3 && big_phases < BIG_PHASE_MAX) begin
            big_phases++;
            set_grid_size(ffc_pkg::field_type'($urandom_range(64, 127)));
            clear_now();
            repeat ($urandom_range(0, 24)) mark_in_grid();
            find_now();
            if ($urandom_range(0, 1) == 1) begin
               mark_in_grid();
               find_now();
            end
         end else begin
            if (pick < 8) size_val = '0;
            else if (pick < 22) size_val = ffc_pkg::field_type'($urandom_range(9, 16));
            else size_val = ffc_pkg::field_type'($urandom_range(1, 8));
            set_grid_size(size_val);
            if (side <= 8 && $urandom_range(0, 9) < 3) begin
               // fill the grid, leaving none, one or two holes unless an earlier mark covers them
               mode   = $urandom_range(0, 2);
               hole_a = (mode > 0) ? $urandom_range(0, side * side - 1) : -1;
               hole_b = (mode > 1) ? $urandom_range(0, side * side - 1) : -1;
               if ($urandom_range(0, 3) != 0) clear_now();
               for (int r = 0; r < side; r++)
                  for (int c = 0; c < side; c++)
                     if (r * side + c != hole_a && r * side + c != hole_b)
                        send_item(ffc_pkg::ACT_MARK, ffc_pkg::field_type'(r + 1),
                                  ffc_pkg::field_type'(c + 1));
               find_now();
            end else begin
               ops = $urandom_range(8, 40);
               repeat (ops) begin
                  pick = $urandom_range(0, 99);
                  if (pick < 60) mark_in_grid();
                  else if (pick < 68)
                     send_item(ffc_pkg::ACT_MARK, ffc_pkg::field_type'($urandom_range(0, 127)),
                               ffc_pkg::field_type'($urandom_range(0, 127)));
                  else if (pick < 90) find_now();
                  else if (pick < 95) clear_now();
                  else
                     send_item(ACT_SPARE, ffc_pkg::field_type'($urandom_range(0, 127)),
                               ffc_pkg::field_type'($urandom_range(0, 127)));
               end
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      waited = 0;
      while ((busy !== 1'b0 || pending != 0) && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending != 0) $error("%0d placements never arrived", pending);
      $display("%0d items sent over %0d grid-size writes, %0d finds issued",
               applied_items, settings_used, find_items);
      $display("%0d placements checked: %0d found, %0d empty grid, %0d full grid",
               checked, n_found, n_empty, n_full);
      if (mismatches == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #1_000_000_000;
      $error("run timed out");
      $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
sv/ffc_pkg.sv
sv/farthest_free_cell_l1_core.sv
test/farthest_cell_checker.sv
test/tb_top.sv
